>>> design/identity_tlv_parser_defines.svh
// ----------------------------------------------------------------------------
// identity_tlv_parser_defines
// Assertion macros shared by the identity TLV parser checkers.
// ----------------------------------------------------------------------------
`ifndef IDENTITY_TLV_PARSER_DEFINES_SVH
`define IDENTITY_TLV_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ITP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types and constants of the identity TLV parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

  typedef enum logic [3:0] {
    PhType  = 4'b0001,
    PhLenHi = 4'b0010,
    PhLenLo = 4'b0100,
    PhValue = 4'b1000
  } itp_phase_e;

  localparam logic [7:0] TypeName  = 8'h01;
  localparam logic [7:0] TypeGrps  = 8'h04;
  localparam logic [7:0] TypeRand  = 8'h07;
  localparam logic [7:0] TypeHost  = 8'h20;
  localparam logic [7:0] IpOpenChr = 8'h5B;

  localparam logic [2:0] TbName     = 3'd0;
  localparam logic [2:0] TbGrps     = 3'd1;
  localparam logic [2:0] TbHost     = 3'd2;
  localparam logic [2:0] TbIp       = 3'd3;
  localparam logic [2:0] TbNone     = 3'd4;
  localparam logic [2:0] TbHostPend = 3'd5;

  localparam logic KindWrite  = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic        kind;
    logic [1:0]  dest_buffer;
    logic [7:0]  char_index;
    logic [7:0]  char_value;
    logic        status_ok;
    logic [15:0] field_count;
    logic        last_of_run;
  } itp_res_t;

  typedef struct packed {
    logic vld0;
    logic vld1;
  } itp_push_t;

  function automatic itp_res_t itp_write(logic [1:0] dest, logic [7:0] idx, logic [7:0] val);
    itp_res_t r;
    r             = '0;
    r.kind        = KindWrite;
    r.dest_buffer = dest;
    r.char_index  = idx;
    r.char_value  = val;
    return r;
  endfunction

endpackage

>>> design/itp_step.sv
// ----------------------------------------------------------------------------
// itp_step
// Record state machine: consumes one byte per transfer and forms up to two
// results for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_step #(
  parameter int unsigned NAME_CAP   = 256,
  parameter int unsigned GROUPS_CAP = 256,
  parameter int unsigned HOST_CAP   = 256,
  parameter int unsigned IP_CAP     = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             req_type_i,
  input  logic [7:0]       data_byte_i,
  output itp_pkg::itp_push_t push_o,
  output itp_pkg::itp_res_t  res0_o,
  output itp_pkg::itp_res_t  res1_o
);
  import itp_pkg::*;

  localparam logic [15:0] NameLim = 16'(NAME_CAP - 1);
  localparam logic [15:0] GrpsLim = 16'(GROUPS_CAP - 1);
  localparam logic [15:0] HostLim = 16'(HOST_CAP - 1);
  localparam logic [15:0] IpLim   = 16'(IP_CAP - 1);

  itp_phase_e  phase_q, phase_d;
  logic [7:0]  rt_q, rt_d;
  logic [7:0]  lh_q, lh_d;
  logic [15:0] bl_q, bl_d;
  logic [15:0] vp_q, vp_d;
  logic [2:0]  tb_q, tb_d;
  logic [15:0] cnt_q, cnt_d;

  logic [15:0] len_w;
  logic [2:0]  sel_tb;
  logic [2:0]  tb_eff;
  logic [15:0] lim_w;
  logic        last_w;
  logic        w0, w1;
  logic [16:0] eff_w;
  logic [7:0]  term_idx;
  itp_res_t    r0, r1;
  itp_push_t   push;

  assign len_w  = {lh_q, data_byte_i};
  assign last_w = (bl_q == 16'd1);
  assign tb_eff = (tb_q == TbHostPend) ? ((data_byte_i == IpOpenChr) ? TbIp : TbHost) : tb_q;
  assign eff_w  = (data_byte_i == 8'd0) ? {1'b0, vp_q} : {1'b0, vp_q} + 17'd1;
  assign term_idx = (eff_w < {1'b0, lim_w}) ? eff_w[7:0] : lim_w[7:0];

  always_comb begin
    case (rt_q)
      TypeName: sel_tb = TbName;
      TypeGrps: sel_tb = TbGrps;
      TypeHost: sel_tb = TbHostPend;
      default:  sel_tb = TbNone;
    endcase
  end

  always_comb begin
    case (tb_eff[1:0])
      2'd0:    lim_w = NameLim;
      2'd1:    lim_w = GrpsLim;
      2'd2:    lim_w = HostLim;
      default: lim_w = IpLim;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    rt_d    = rt_q;
    lh_d    = lh_q;
    bl_d    = bl_q;
    vp_d    = vp_q;
    tb_d    = tb_q;
    cnt_d   = cnt_q;
    r0      = '0;
    r1      = '0;
    push    = '0;
    w0      = 1'b0;
    w1      = 1'b0;
    if (accept_i && req_type_i) begin
      r0.kind        = KindStatus;
      r0.status_ok   = (phase_q == PhType) && (cnt_q != 16'd0);
      r0.field_count = cnt_q;
      push.vld0      = 1'b1;
      phase_d = PhType;
      rt_d    = '0;
      lh_d    = '0;
      bl_d    = '0;
      vp_d    = '0;
      tb_d    = TbNone;
      cnt_d   = '0;
    end else if (accept_i) begin
      case (phase_q)
        PhType: begin
          rt_d    = data_byte_i;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          lh_d    = data_byte_i;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          bl_d = len_w;
          vp_d = '0;
          if (rt_q != TypeRand && cnt_q != 16'hFFFF) begin
            cnt_d = cnt_q + 16'd1;
          end
          if (len_w == 16'd0) begin
            if (sel_tb != TbNone) begin
              r0        = itp_write((sel_tb == TbHostPend) ? TbHost[1:0] : sel_tb[1:0],
                                    8'd0, 8'd0);
              push.vld0 = 1'b1;
            end
            tb_d    = TbNone;
            phase_d = PhType;
          end else begin
            tb_d    = sel_tb;
            phase_d = PhValue;
          end
        end
        PhValue: begin
          bl_d = bl_q - 16'd1;
          vp_d = vp_q + 16'd1;
          if (!tb_eff[2]) begin
            w0 = !(last_w && data_byte_i == 8'd0) && (vp_q < lim_w);
            w1 = last_w;
          end
          if (w0) begin
            r0        = itp_write(tb_eff[1:0], vp_q[7:0], data_byte_i);
            push.vld0 = 1'b1;
            if (w1) begin
              r1        = itp_write(tb_eff[1:0], term_idx, 8'd0);
              push.vld1 = 1'b1;
            end
          end else if (w1) begin
            r0        = itp_write(tb_eff[1:0], term_idx, 8'd0);
            push.vld0 = 1'b1;
          end
          if (last_w) begin
            phase_d = PhType;
            tb_d    = TbNone;
          end else begin
            tb_d    = tb_eff;
          end
        end
        default: begin
          phase_d = PhType;
        end
      endcase
    end
    if (push.vld1) begin
      r1.last_of_run = 1'b1;
    end else if (push.vld0) begin
      r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      rt_q    <= '0;
      lh_q    <= '0;
      bl_q    <= '0;
      vp_q    <= '0;
      tb_q    <= TbNone;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rt_q    <= rt_d;
      lh_q    <= lh_d;
      bl_q    <= bl_d;
      vp_q    <= vp_d;
      tb_q    <= tb_d;
      cnt_q   <= cnt_d;
    end
  end

  assign push_o = push;
  assign res0_o = r0;
  assign res1_o = r1;

endmodule

>>> design/itp_res_fifo.sv
// ----------------------------------------------------------------------------
// itp_res_fifo
// Result queue: takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itp_pkg::itp_push_t push_i,
  input  itp_pkg::itp_res_t  res0_i,
  input  itp_pkg::itp_res_t  res1_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output itp_pkg::itp_res_t  head_o
);
  import itp_pkg::*;

  itp_res_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d;
  logic [QPtrW-1:0]   rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic [QPtrW-1:0]   wr_nxt;
  logic [QCntW-1:0]   n_push;
  logic               pop;

  assign wr_nxt = wr_q + QPtrW'(1);
  assign n_push = QCntW'(push_i.vld0) + QCntW'(push_i.vld1);
  assign pop    = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q + n_push[QPtrW-1:0];
    rd_d  = pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + n_push - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.vld1) begin
      mem_q[wr_nxt] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // hold off input unless two slots are free
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];

endmodule

>>> design/identity_tlv_parser.sv
// ----------------------------------------------------------------------------
// identity_tlv_parser
// Each result is written into the result queue and offered on out_valid_o from there.
// Throughput: one byte per cycle; a byte that ends a field gives up to two results,
// and in_ready_o drops while the four-entry result queue holds three or more.
// Reset: rst_ni clears the record state, the field count and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module identity_tlv_parser #(
  parameter int unsigned NAME_CAP   = 256,
  parameter int unsigned GROUPS_CAP = 256,
  parameter int unsigned HOST_CAP   = 256,
  parameter int unsigned IP_CAP     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [1:0]  dest_buffer_o,
  output logic [7:0]  char_index_o,
  output logic [7:0]  char_value_o,
  output logic        status_ok_o,
  output logic [15:0] field_count_o,
  output logic        last_of_run_o
);
  import itp_pkg::*;

  itp_push_t push;
  itp_res_t  res0, res1, head;
  logic      accept;

  assign accept = in_valid_i && in_ready_o;

  itp_step #(
    .NAME_CAP  (NAME_CAP),
    .GROUPS_CAP(GROUPS_CAP),
    .HOST_CAP  (HOST_CAP),
    .IP_CAP    (IP_CAP)
  ) u_itp_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .data_byte_i(data_byte_i),
    .push_o     (push),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  itp_res_fifo u_itp_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res0_i     (res0),
    .res1_i     (res1),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign kind_o        = head.kind;
  assign dest_buffer_o = head.dest_buffer;
  assign char_index_o  = head.char_index;
  assign char_value_o  = head.char_value;
  assign status_ok_o   = head.status_ok;
  assign field_count_o = head.field_count;
  assign last_of_run_o = head.last_of_run;

endmodule

>>> design/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks of the identity TLV parser result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "identity_tlv_parser_defines.svh"

module itp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        kind_i,
  input logic [1:0]  dest_buffer_i,
  input logic [7:0]  char_index_i,
  input logic [7:0]  char_value_i,
  input logic        status_ok_i,
  input logic [15:0] field_count_i,
  input logic        last_of_run_i
);
  import itp_pkg::*;

  `ITP_ASSERT_IMPL(a_status_shape, clk_i, rst_ni, out_valid_i && kind_i == KindStatus, last_of_run_i && dest_buffer_i == 2'd0 && char_index_i == 8'd0 && char_value_i == 8'd0, "status result malformed")
  `ITP_ASSERT_IMPL(a_write_shape, clk_i, rst_ni, out_valid_i && kind_i == KindWrite, !status_ok_i && field_count_i == 16'd0, "write result carries status")
  `ITP_ASSERT_IMPL(a_ok_count, clk_i, rst_ni, out_valid_i && status_ok_i, field_count_i != 16'd0, "ok status with zero count")
  `ITP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(char_value_i) && $stable(field_count_i), "stalled result changed")

endmodule

bind identity_tlv_parser itp_checker u_itp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_i       (kind_o),
  .dest_buffer_i(dest_buffer_o),
  .char_index_i (char_index_o),
  .char_value_i (char_value_o),
  .status_ok_i  (status_ok_o),
  .field_count_i(field_count_o),
  .last_of_run_i(last_of_run_o)
);

>>> tb/sv/identity_tlv_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identity_tlv_parser_tb
// Feeds identity blocks byte by byte through the TLV parser and scores every
// result transfer against an in-bench prediction. A short table of hand-picked
// bytes comes first, then random blocks under several idle and stall mixes,
// and a long receiver hold-off.
// ----------------------------------------------------------------------------

module identity_tlv_parser_tb;
  import itp_pkg::*;

  localparam int unsigned NameCap    = 256;
  localparam int unsigned GrpsCap    = 256;
  localparam int unsigned HostCap    = 256;
  localparam int unsigned IpCap      = 64;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic       eob;
    logic [7:0] b;
    int         nfix;
    itp_res_t   r0;
    itp_res_t   r1;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        kind_o;
  logic [1:0]  dest_buffer_o;
  logic [7:0]  char_index_o;
  logic [7:0]  char_value_o;
  logic        status_ok_o;
  logic [15:0] field_count_o;
  logic        last_of_run_o;

  identity_tlv_parser #(
    .NAME_CAP  (NameCap),
    .GROUPS_CAP(GrpsCap),
    .HOST_CAP  (HostCap),
    .IP_CAP    (IpCap)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .dest_buffer_o(dest_buffer_o),
    .char_index_o (char_index_o),
    .char_value_o (char_value_o),
    .status_ok_o  (status_ok_o),
    .field_count_o(field_count_o),
    .last_of_run_o(last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  itp_phase_e  rec_phase;
  logic [7:0]  rec_type;
  logic [7:0]  len_hi;
  logic [15:0] bytes_left;
  logic [15:0] val_pos;
  logic [2:0]  dest_sel;
  logic [15:0] field_cnt;

  itp_res_t    expected_q[$];
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned hold_cycles  = 0;
  int unsigned sent_items   = 0;
  int unsigned fail_cnt     = 0;

  function automatic itp_res_t mk_res(logic k, logic [1:0] d, logic [7:0] idx,
                                      logic [7:0] v, logic ok, logic [15:0] cnt,
                                      logic lst);
    itp_res_t r;
    r.kind        = k;
    r.dest_buffer = d;
    r.char_index  = idx;
    r.char_value  = v;
    r.status_ok   = ok;
    r.field_count = cnt;
    r.last_of_run = lst;
    return r;
  endfunction

  function automatic void clear_record_state();
    rec_phase  = PhType;
    rec_type   = '0;
    len_hi     = '0;
    bytes_left = '0;
    val_pos    = '0;
    dest_sel   = TbNone;
    field_cnt  = '0;
  endfunction

  function automatic int unsigned cap_less_one(logic [2:0] sel);
    case (sel)
      TbName:  return NameCap - 1;
      TbGrps:  return GrpsCap - 1;
      TbHost:  return HostCap - 1;
      default: return IpCap - 1;
    endcase
  endfunction

  function automatic int predict_item(input logic eob, input logic [7:0] b,
                                      output itp_res_t res [2]);
    int          n;
    int unsigned lim;
    int unsigned pos;
    int unsigned term;
    logic        done;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (eob) begin
      res[0] = mk_res(KindStatus, 2'd0, 8'd0, 8'd0,
                      rec_phase == PhType && field_cnt != 16'd0, field_cnt, 1'b1);
      clear_record_state();
      return 1;
    end
    case (rec_phase)
      PhType: begin
        rec_type  = b;
        rec_phase = PhLenHi;
      end
      PhLenHi: begin
        len_hi    = b;
        rec_phase = PhLenLo;
      end
      PhLenLo: begin
        bytes_left = {len_hi, b};
        val_pos    = '0;
        if (rec_type != TypeRand && field_cnt != 16'hFFFF) field_cnt++;
        case (rec_type)
          TypeName: dest_sel = TbName;
          TypeGrps: dest_sel = TbGrps;
          TypeHost: dest_sel = TbHostPend;
          default:  dest_sel = TbNone;
        endcase
        if (bytes_left == 16'd0) begin
          if (dest_sel == TbHostPend) dest_sel = TbHost;
          if (dest_sel != TbNone) begin
            res[n] = mk_res(KindWrite, dest_sel[1:0], 8'd0, 8'd0, 1'b0, 16'd0, 1'b0);
            n++;
          end
          dest_sel  = TbNone;
          rec_phase = PhType;
        end else begin
          rec_phase = PhValue;
        end
      end
      default: begin
        if (dest_sel == TbHostPend) dest_sel = (b == IpOpenChr) ? TbIp : TbHost;
        bytes_left--;
        done = (bytes_left == 16'd0);
        if (dest_sel != TbNone) begin
          lim = cap_less_one(dest_sel);
          pos = val_pos;
          if (!(done && b == 8'd0) && pos < lim) begin
            res[n] = mk_res(KindWrite, dest_sel[1:0], 8'(pos), b, 1'b0, 16'd0, 1'b0);
            n++;
          end
          if (done) begin
            term   = (b == 8'd0) ? pos : pos + 1;
            res[n] = mk_res(KindWrite, dest_sel[1:0], 8'(term < lim ? term : lim), 8'd0,
                            1'b0, 16'd0, 1'b0);
            n++;
          end
        end
        val_pos++;
        if (done) begin
          rec_phase = PhType;
          dest_sel  = TbNone;
        end
      end
    endcase
    if (n > 0) res[n-1].last_of_run = 1'b1;
    return n;
  endfunction

  task automatic send_item(input logic eob, input logic [7:0] b);
    logic took;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= eob;
    data_byte_i <= b;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    sent_items++;
  endtask

  task automatic push_byte(input logic eob, input logic [7:0] b);
    itp_res_t res [2];
    int       n;
    send_item(eob, b);
    n = predict_item(eob, b, res);
    for (int j = 0; j < n; j++) expected_q.push_back(res[j]);
  endtask

  task automatic send_record(input int unsigned cut);
    logic [7:0]  typ;
    logic [15:0] len;
    logic [7:0]  b;
    int unsigned r;
    case ($urandom_range(9))
      0, 1:    typ = TypeName;
      2, 3:    typ = TypeGrps;
      4, 5, 6: typ = TypeHost;
      7:       typ = TypeRand;
      default: typ = 8'($urandom);
    endcase
    r = $urandom_range(39);
    if (r == 0) len = 16'($urandom_range(250, 300));
    else if (r == 1) len = 16'($urandom_range(60, 70));
    else if (r < 5) len = 16'd0;
    else len = 16'($urandom_range(1, 8));
    for (int unsigned i = 0; i < len + 3 && i < cut; i++) begin
      if (i == 0) b = typ;
      else if (i == 1) b = len[15:8];
      else if (i == 2) b = len[7:0];
      else begin
        b = 8'($urandom);
        if (i == 3 && typ == TypeHost && $urandom_range(1) == 1) b = IpOpenChr;
        if (i == len + 2 && $urandom_range(2) == 0) b = 8'd0;
      end
      push_byte(1'b0, b);
    end
  endtask

  task automatic send_block();
    int unsigned nrec;
    int unsigned shape;
    shape = $urandom_range(7);
    if (shape == 0) begin
      repeat ($urandom_range(1, 6)) push_byte(1'b0, 8'($urandom));
    end else begin
      nrec = $urandom_range(1, 4);
      for (int unsigned i = 0; i < nrec; i++) begin
        send_record((shape == 1 && i == nrec - 1) ? $urandom_range(0, 6) : 32'hFFFF_FFFF);
      end
    end
    push_byte(1'b1, 8'($urandom));
  endtask

  function automatic void note_fail(string what, itp_res_t want, itp_res_t got);
    fail_cnt++;
    if (fail_cnt <= MaxReports) begin
      $display("%0t %s: exp kind=%0d dst=%0d idx=%0d val=%02h ok=%0d cnt=%0d last=%0d",
               $time, what, want.kind, want.dest_buffer, want.char_index, want.char_value,
               want.status_ok, want.field_count, want.last_of_run);
      $display("%0t %s: got kind=%0d dst=%0d idx=%0d val=%02h ok=%0d cnt=%0d last=%0d",
               $time, what, got.kind, got.dest_buffer, got.char_index, got.char_value,
               got.status_ok, got.field_count, got.last_of_run);
    end
  endfunction

  initial begin : result_sink
    itp_res_t got;
    itp_res_t want;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= dst_idle_pct);
      end
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {kind_o, dest_buffer_o, char_index_o, char_value_o, status_ok_o,
               field_count_o, last_of_run_o};
        if (expected_q.size() == 0) begin
          note_fail("unexpected transfer", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) note_fail("mismatch", want, got);
        end
      end
    end
  end

  initial begin : watchdog
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   stim_tab [25];
    itp_res_t    res [2];
    int          n;
    int unsigned goal;
    int unsigned src_mix [4];
    int unsigned dst_mix [4];

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= 1'b0;
    data_byte_i <= 8'd0;
    clear_record_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stim_tab = '{
      '{1'b1, 8'hA5, 1, mk_res(KindStatus, 2'd0, 8'd0, 8'd0, 1'b0, 16'd0, 1'b1), '0},
      '{1'b0, TypeHost,  -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b0, 8'h02,     -1, '0, '0},
      '{1'b0, IpOpenChr, -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b0, TypeRand,  -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b0, 8'h01,     -1, '0, '0},
      '{1'b0, 8'hFF,     -1, '0, '0},
      '{1'b0, TypeGrps,  -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b0, 8'h02,     -1, '0, '0},
      '{1'b0, 8'hFF,     -1, '0, '0},
      '{1'b0, 8'h41,     -1, '0, '0},
      '{1'b0, 8'hFF,     -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b0, TypeHost,  -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b0, 8'h00, 1, mk_res(KindWrite, TbHost[1:0], 8'd0, 8'd0, 1'b0, 16'd0, 1'b1), '0},
      '{1'b1, 8'h5A, 1, mk_res(KindStatus, 2'd0, 8'd0, 8'd0, 1'b1, 16'd4, 1'b1), '0},
      '{1'b0, TypeName,  -1, '0, '0},
      '{1'b0, 8'h00,     -1, '0, '0},
      '{1'b1, 8'hFF, 1, mk_res(KindStatus, 2'd0, 8'd0, 8'd0, 1'b0, 16'd0, 1'b1), '0}
    };

    foreach (stim_tab[i]) begin
      send_item(stim_tab[i].eob, stim_tab[i].b);
      n = predict_item(stim_tab[i].eob, stim_tab[i].b, res);
      if (stim_tab[i].nfix < 0) begin
        for (int j = 0; j < n; j++) expected_q.push_back(res[j]);
      end else begin
        expected_q.push_back(stim_tab[i].r0);
        if (stim_tab[i].nfix == 2) expected_q.push_back(stim_tab[i].r1);
      end
    end

    src_mix = '{0, 84, 0, 12};
    dst_mix = '{0, 0, 84, 12};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_mix[p];
      dst_idle_pct = dst_mix[p];
      goal         = sent_items + 150;
      while (sent_items < goal) send_block();
    end

    // hold the sink off while bytes keep coming, so the result queue fills
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_cycles  = 400;
    repeat (6) send_block();

    push_byte(1'b1, 8'($urandom));

    in_valid_i <= 1'b0;
    for (int w = 0; w < 200000 && expected_q.size() != 0; w++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      fail_cnt++;
      $display("%0t %0d results never arrived", $time, expected_q.size());
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/itp_pkg.sv
design/itp_step.sv
design/itp_res_fifo.sv
design/identity_tlv_parser.sv
design/itp_checker.sv
tb/sv/identity_tlv_parser_tb.sv
